@@ sv/bmc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared constants, register codes and pipeline types of the bit mask crusher.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

  localparam int MAG_BITS   = 15;
  localparam int SAMPLE_W   = 16;
  localparam int OUT_MAG_W  = 15;
  localparam int MASK_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int SQ_W       = 2 * MAG_BITS;
  localparam int RAD_W      = 3 * MAG_BITS;
  localparam int REM_W      = 2 * MAG_BITS + 3;
  localparam int RECIP_W    = MAG_BITS + 1;

  localparam logic [MAG_BITS-1:0]  FULL_SCALE = {MAG_BITS{1'b1}};
  localparam logic [SQ_W-1:0]      FS_SQ      = SQ_W'(FULL_SCALE) * SQ_W'(FULL_SCALE);
  localparam logic [RAD_W:0]       CUBE_ONE   = {1'b1, {RAD_W{1'b0}}};
  localparam logic [RAD_W:0]       RECIP_WIDE = CUBE_ONE / (RAD_W + 1)'(FS_SQ);
  localparam logic [RECIP_W-1:0]   RECIP      = RECIP_WIDE[RECIP_W-1:0];
  localparam logic [OUT_MAG_W-1:0] OUT_MAX    = {OUT_MAG_W{1'b1}};

  localparam int FRONT_STAGES = 2;
  localparam int BACK_STAGES  = 6;
  localparam int LATENCY      = FRONT_STAGES + MAG_BITS + BACK_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_MASK   = 2'd0,
    REG_XOR_EN     = 2'd1,
    REG_AND_EN     = 2'd2,
    REG_COMPAND_EN = 2'd3
  } bmc_reg_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] bit_mask;
    logic                xor_en;
    logic                and_en;
    logic                compand_en;
  } bmc_cfg_t;

  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
    logic [MAG_BITS-1:0] root;
    logic [SQ_W-1:0]     ysq;
    logic [REM_W-1:0]    rem;
    logic [RAD_W-1:0]    rad;
  } bmc_cbrt_t;

endpackage

`default_nettype wire

@@ sv/bmc_front.sv @@
// ----------------------------------------------------------------------------
// bmc_front
// Sign split, magnitude saturation and scaling of the cube root radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_front
  import bmc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_vld,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic                            out_vld,
  output bmc_cbrt_t                       out_d
);

  logic [SAMPLE_W-1:0]         raw;
  logic [SAMPLE_W:0]           mag_full;
  logic [MAG_BITS+SAMPLE_W:0]  mag_ext;
  logic [MAG_BITS-1:0]         mag_sat;
  logic                        vld1;
  logic                        neg1;
  logic [MAG_BITS-1:0]         mag1;

  always_comb begin
    raw      = sample_in;
    mag_full = raw[SAMPLE_W-1] ? ({1'b1, {SAMPLE_W{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
    mag_ext  = (MAG_BITS + SAMPLE_W + 1)'(mag_full);
    mag_sat  = (mag_ext > (MAG_BITS + SAMPLE_W + 1)'(FULL_SCALE)) ? FULL_SCALE
                                                                 : mag_ext[MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    neg1       <= raw[SAMPLE_W-1];
    mag1       <= mag_sat;
    out_d.neg  <= neg1;
    out_d.mag  <= mag1;
    out_d.root <= '0;
    out_d.ysq  <= '0;
    out_d.rem  <= '0;
    out_d.rad  <= RAD_W'(mag1) * RAD_W'(FS_SQ);
  end

endmodule

`default_nettype wire

@@ sv/bmc_cbrt_step.sv @@
// ----------------------------------------------------------------------------
// bmc_cbrt_step
// One registered step of the digit-by-digit cube root: one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_cbrt_step
  import bmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_vld,
  input  bmc_cbrt_t      in_d,
  output logic           out_vld,
  output bmc_cbrt_t      out_d
);

  logic [2:0]          digit;
  logic [MAG_BITS-1:0] y2;
  logic [SQ_W-1:0]     ysq2;
  logic [SQ_W-1:0]     pair;
  logic [REM_W-1:0]    trial;
  logic [REM_W-1:0]    rcat;
  logic                take;

  always_comb begin
    digit = in_d.rad[RAD_W-1 -: 3];
    y2    = in_d.root << 1;
    ysq2  = in_d.ysq << 2;
    pair  = ysq2 + SQ_W'(y2);
    trial = REM_W'(pair) + (REM_W'(pair) << 1) + REM_W'(1);
    rcat  = {in_d.rem[REM_W-4:0], digit};
    take  = (rcat >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_d.neg <= in_d.neg;
    out_d.mag <= in_d.mag;
    out_d.rad <= in_d.rad << 3;
    if (take) begin
      out_d.rem  <= rcat - trial;
      out_d.root <= y2 | MAG_BITS'(1);
      out_d.ysq  <= ysq2 + SQ_W'({y2, 1'b0}) + SQ_W'(1);
    end else begin
      out_d.rem  <= rcat;
      out_d.root <= y2;
      out_d.ysq  <= ysq2;
    end
  end

endmodule

`default_nettype wire

@@ sv/bmc_back.sv @@
// ----------------------------------------------------------------------------
// bmc_back
// Mask stage, scaled cube by reciprocal multiply, sign restore and output.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_back
  import bmc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_vld,
  input  bmc_cbrt_t                 in_d,
  input  bmc_cfg_t                  cfg,
  output logic                      done,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam logic [SQ_W+1:0] DIV1 = (SQ_W + 2)'(FS_SQ);
  localparam logic [SQ_W+1:0] DIV2 = (SQ_W + 2)'(FS_SQ) << 1;

  logic [BACK_STAGES-2:0] vld;

  logic [MAG_BITS-1:0] sel;
  logic [MAG_BITS-1:0] masked;
  logic                a_neg;
  logic [MAG_BITS-1:0] a_x;
  logic                b_neg;
  logic [MAG_BITS-1:0] b_x;
  logic [SQ_W-1:0]     b_sq;
  logic                c_neg;
  logic [MAG_BITS-1:0] c_x;
  logic [RAD_W-1:0]    c_cu;
  logic                d_neg;
  logic [MAG_BITS-1:0] d_x;
  logic [RAD_W-1:0]    d_cu;
  logic [MAG_BITS-1:0] d_qe;
  logic                e_neg;
  logic [MAG_BITS-1:0] e_x;
  logic [MAG_BITS-1:0] e_qe;
  logic [SQ_W+1:0]     e_rem;

  logic [RAD_W:0]              prod_r;
  logic [RAD_W-1:0]            prod_d;
  logic [MAG_BITS-1:0]         q;
  logic [MAG_BITS-1:0]         mag_f;
  logic [MAG_BITS+OUT_MAG_W:0] mag_ext;
  logic [OUT_MAG_W-1:0]        mag_o;

  always_comb begin
    sel    = cfg.compand_en ? in_d.root : in_d.mag;
    masked = cfg.xor_en ? (sel ^ cfg.bit_mask) : sel;
    masked = cfg.and_en ? (masked & cfg.bit_mask) : masked;
  end

  always_comb begin
    prod_r = (RAD_W + 1)'(c_cu[RAD_W-1:MAG_BITS]) * (RAD_W + 1)'(RECIP);
    prod_d = RAD_W'(d_qe) * RAD_W'(FS_SQ);
  end

  always_comb begin
    if (e_rem >= DIV2) begin
      q = e_qe + MAG_BITS'(2);
    end else if (e_rem >= DIV1) begin
      q = e_qe + MAG_BITS'(1);
    end else begin
      q = e_qe;
    end
    mag_f   = cfg.compand_en ? q : e_x;
    mag_ext = (MAG_BITS + OUT_MAG_W + 1)'(mag_f);
    mag_o   = (mag_ext > (MAG_BITS + OUT_MAG_W + 1)'(OUT_MAX)) ? OUT_MAX
                                                              : mag_ext[OUT_MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[BACK_STAGES-3:0], in_vld};
      done <= vld[BACK_STAGES-2];
    end
  end

  always_ff @(posedge clk) begin
    a_neg <= in_d.neg;
    a_x   <= masked;
    b_neg <= a_neg;
    b_x   <= a_x;
    b_sq  <= SQ_W'(a_x) * SQ_W'(a_x);
    c_neg <= b_neg;
    c_x   <= b_x;
    c_cu  <= RAD_W'(b_sq) * RAD_W'(b_x);
    d_neg <= c_neg;
    d_x   <= c_x;
    d_cu  <= c_cu;
    d_qe  <= prod_r[RAD_W-1:SQ_W];
    e_neg <= d_neg;
    e_x   <= d_x;
    e_qe  <= d_qe;
    e_rem <= d_cu[SQ_W+1:0] - prod_d[SQ_W+1:0];
    if (e_neg) begin
      sample_out <= SAMPLE_W'(0) - {1'b0, mag_o};
    end else begin
      sample_out <= {1'b0, mag_o};
    end
  end

endmodule

`default_nettype wire

@@ sv/audio_bit_mask_crusher_unit.sv @@
// ----------------------------------------------------------------------------
// audio_bit_mask_crusher_unit
// Per-sample bit mask crusher with optional cube root companding.
//
// channel   ports                              handshake
// input     start, busy, sample_in             start & !busy
// result    done, sample_out                   done, one cycle, no back-pressure
// config    cfg_we, cfg_index, cfg_data        cfg_we
//
// One transaction enters per cycle; busy is always low.
// A sample passes the front stages, then the cube root chain, which resolves
// one root bit per pipeline stage, and then the back stages.
// Synchronous reset clears the valid pipeline and all configuration registers.
// Nothing stalls: every accepted transaction yields exactly one done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_bit_mask_crusher_unit
  import bmc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in,
  output logic                             done,
  output logic signed [SAMPLE_W-1:0]       sample_out,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  logic [MASK_W-1:0]          bit_mask;
  logic                       xor_enable;
  logic                       and_enable;
  logic                       compand_enable;
  logic [MAG_BITS+MASK_W-1:0] mask_ext;
  bmc_cfg_t                   cfg;

  logic      chain_vld [MAG_BITS+1];
  bmc_cbrt_t chain_d   [MAG_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_mask       <= '0;
      xor_enable     <= 1'b0;
      and_enable     <= 1'b0;
      compand_enable <= 1'b0;
    end else if (cfg_we) begin
      case (bmc_reg_t'(cfg_index))
        REG_BIT_MASK:   bit_mask       <= cfg_data[MASK_W-1:0];
        REG_XOR_EN:     xor_enable     <= cfg_data[0];
        REG_AND_EN:     and_enable     <= cfg_data[0];
        REG_COMPAND_EN: compand_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy           = 1'b0;
    mask_ext       = (MAG_BITS + MASK_W)'(bit_mask);
    cfg.bit_mask   = mask_ext[MAG_BITS-1:0];
    cfg.xor_en     = xor_enable;
    cfg.and_en     = and_enable;
    cfg.compand_en = compand_enable;
  end

  bmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start & ~busy),
    .sample_in (sample_in),
    .out_vld   (chain_vld[0]),
    .out_d     (chain_d[0])
  );

  for (genvar i = 0; i < MAG_BITS; i++) begin : g_cbrt
    bmc_cbrt_step u_step (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (chain_vld[i]),
      .in_d    (chain_d[i]),
      .out_vld (chain_vld[i+1]),
      .out_d   (chain_d[i+1])
    );
  end

  bmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (chain_vld[MAG_BITS]),
    .in_d       (chain_d[MAG_BITS]),
    .cfg        (cfg),
    .done       (done),
    .sample_out (sample_out)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction produced no result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result without an accepted transaction");

  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (sample_out != {1'b1, {(SAMPLE_W-1){1'b0}}}))
    else $error("result magnitude beyond full scale");

endmodule

`default_nettype wire

@@ verif/audio_bit_mask_crusher_checker.sv @@
// ----------------------------------------------------------------------------
// audio_bit_mask_crusher_checker
// Scoreboard for the bit mask crusher. It tracks the register writes,
// predicts each sample from the transactions accepted at the input, and
// compares every done pulse in order with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_bit_mask_crusher_checker
  import bmc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       done,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         mismatches,
  output int                         outstanding
);

  localparam longint unsigned SCALE = (64'd1 << MAG_BITS) - 64'd1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] crushed;
  } crush_pair_t;

  bmc_cfg_t    cfg_shadow;
  crush_pair_t expected_out_q[$];
  int          error_count;

  assign mismatches = error_count;

  function automatic logic [MAG_BITS-1:0] scaled_cbrt(input logic [MAG_BITS-1:0] m);
    longint unsigned target;
    longint unsigned trial;
    logic [MAG_BITS-1:0] root;
    target = longint'(m) * SCALE * SCALE;
    root = '0;
    for (int b = MAG_BITS - 1; b >= 0; b--) begin
      trial = longint'(root) | (64'd1 << b);
      if (trial * trial * trial <= target) begin
        root = trial[MAG_BITS-1:0];
      end
    end
    return root;
  endfunction

  function automatic logic [MAG_BITS-1:0] scaled_cube(input logic [MAG_BITS-1:0] x);
    longint unsigned q;
    q = (longint'(x) * longint'(x) * longint'(x)) / (SCALE * SCALE);
    return q[MAG_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] crush_predict(
    input logic signed [SAMPLE_W-1:0] s,
    input bmc_cfg_t                   cfg
  );
    int              v;
    longint unsigned mag;
    logic [MAG_BITS-1:0] code;
    int              res;
    v = s;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    if (mag > SCALE) begin
      mag = SCALE;
    end
    code = mag[MAG_BITS-1:0];
    if (cfg.compand_en) begin
      code = scaled_cbrt(code);
    end
    if (cfg.xor_en) begin
      code = code ^ cfg.bit_mask;
    end
    if (cfg.and_en) begin
      code = code & cfg.bit_mask;
    end
    if (cfg.compand_en) begin
      code = scaled_cube(code);
    end
    res = (v < 0) ? -int'(code) : int'(code);
    return res[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 40) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    error_count++;
  endtask

  initial begin
    error_count = 0;
    outstanding = 0;
    cfg_shadow = '0;
  end

  always @(posedge clk) begin
    crush_pair_t pair;
    if (rst) begin
      cfg_shadow = '0;
      expected_out_q.delete();
    end else begin
      if (done) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", sample_out));
        end else begin
          pair = expected_out_q.pop_front();
          if (sample_out !== pair.crushed) begin
            report_mismatch($sformatf("sample_in %0d: sample_out %0d, expected %0d",
                                      pair.sample, sample_out, pair.crushed));
          end
        end
      end
      if (start && !busy) begin
        pair.sample  = sample_in;
        pair.crushed = crush_predict(sample_in, cfg_shadow);
        expected_out_q = {expected_out_q, pair};
      end
      if (cfg_we) begin
        case (bmc_reg_t'(cfg_index))
          REG_BIT_MASK:   cfg_shadow.bit_mask   = cfg_data[MASK_W-1:0];
          REG_XOR_EN:     cfg_shadow.xor_en     = cfg_data[0];
          REG_AND_EN:     cfg_shadow.and_en     = cfg_data[0];
          REG_COMPAND_EN: cfg_shadow.compand_en = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_out_q.size();
  end

endmodule

@@ verif/audio_bit_mask_crusher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// audio_bit_mask_crusher_unit_tb
// Drives the bit mask crusher through directed corner samples and random
// sample streams under a series of mask and mode settings, with random
// gaps between transactions, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_bit_mask_crusher_unit_tb;
  import bmc_pkg::*;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       done;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  int                         mismatches;
  int                         outstanding;
  bit                         burst_mode;

  audio_bit_mask_crusher_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .done       (done),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  audio_bit_mask_crusher_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample_in   (sample_in),
    .done        (done),
    .sample_out  (sample_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int sel;
    int gap;
    start     <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (busy);
    sel = $urandom_range(0, 99);
    if (burst_mode || sel < 60) begin
      gap = 0;
    end else if (sel < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the pipeline before touching the registers.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input bmc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_modes(input logic [MASK_W-1:0] mask, input bit xr, input bit an,
                           input bit cp);
    drain();
    write_reg(REG_BIT_MASK, mask);
    write_reg(REG_XOR_EN, CFG_DATA_W'(xr));
    write_reg(REG_AND_EN, CFG_DATA_W'(an));
    write_reg(REG_COMPAND_EN, CFG_DATA_W'(cp));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      return SAMPLE_W'($urandom);
    end else if (sel < 85) begin
      case ($urandom_range(0, 5))
        0: return -16'sd32768;
        1: return -16'sd32767;
        2: return -16'sd1;
        3: return 16'sd0;
        4: return 16'sd1;
        default: return 16'sd32767;
      endcase
    end
    return SAMPLE_W'($urandom_range(0, 512) - 256);
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return MASK_W'(1) << (MASK_W - 1);
      3: return MASK_W'(1);
      default: return MASK_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] corners[$];
    rst        <= 1'b1;
    start      <= 1'b0;
    sample_in  <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_BIT_MASK;
    cfg_data   <= '0;
    burst_mode = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset modes: plain sign/magnitude pass with saturation.
    corners = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32767, -16'sd32768,
                16'sd16384, -16'sd16384, 16'sh5555, -16'sd10923};
    foreach (corners[i]) send_sample(corners[i]);

    // Full mask XOR: top magnitude cancels to a zero result.
    set_modes('1, 1'b1, 1'b0, 1'b0);
    corners = '{16'sd32767, -16'sd32768, -16'sd32767, 16'sd0, 16'sh2AAA};
    foreach (corners[i]) send_sample(corners[i]);

    // Single-bit AND mask inside the companding path.
    set_modes(MASK_W'(1) << (MASK_W - 1), 1'b0, 1'b1, 1'b1);
    corners = '{16'sd0, 16'sd1, 16'sd32767, -16'sd32768, -16'sd1};
    foreach (corners[i]) send_sample(corners[i]);

    // All modes with the full mask, then with none.
    set_modes('1, 1'b1, 1'b1, 1'b1);
    corners = '{16'sd1, -16'sd300, 16'sd32767};
    foreach (corners[i]) send_sample(corners[i]);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_modes('0, 1'b1, 1'b1, 1'b1);
        1: set_modes('0, 1'b0, 1'b0, 1'b1);
        2: set_modes('1, 1'b0, 1'b1, 1'b0);
        default: set_modes(random_mask(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (60) send_sample(random_sample());
    end
    burst_mode = 1'b0;

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
